@@ rtl/svpf_pkg.sv @@
// Package for the servo command packet framer.
// Holds packet constants and the frame type shared by the frame builder and the top level.
// Depends on nothing.
package svpf_pkg;

  localparam int unsigned FrameBytes = 10;
  localparam int unsigned CountW     = $clog2(FrameBytes + 1);

  localparam logic [7:0] HdrByte  = 8'h55;
  localparam logic [7:0] MoveLen  = 8'd7;
  localparam logic [7:0] MoveCode = 8'd1;
  localparam logic [7:0] ReadLen  = 8'd3;
  localparam logic [7:0] ReadCode = 8'h1C;
  localparam logic [7:0] ByteMask = 8'hFF;

  localparam logic [CountW-1:0] MoveBytes = CountW'(10);
  localparam logic [CountW-1:0] ReadBytes = CountW'(6);

  localparam logic CmdMove = 1'b0;
  localparam logic CmdRead = 1'b1;

  typedef struct packed {
    logic [FrameBytes-1:0][7:0] data;
    logic [CountW-1:0]          count;
  } frame_t;

endpackage

@@ rtl/svpf_frame_build.sv @@
// Frame builder for the servo command packet framer.
// Lays out the header, body and inverted-sum checksum of one command as a byte frame.
// Depends on svpf_pkg.
module svpf_frame_build (
  input  logic            cmd,
  input  logic [7:0]      servo_id,
  input  logic [15:0]     target_angle,
  input  logic [15:0]     move_time,
  output svpf_pkg::frame_t frame
);
  import svpf_pkg::*;

  logic [7:0] len_byte;
  logic [7:0] code_byte;
  logic [7:0] angle_lo;
  logic [7:0] angle_hi;
  logic [7:0] time_lo;
  logic [7:0] time_hi;
  logic [7:0] sum;
  logic [7:0] chk;

  always_comb begin
    if (cmd == CmdMove) begin
      len_byte  = MoveLen;
      code_byte = MoveCode;
      angle_lo  = target_angle[7:0];
      angle_hi  = target_angle[15:8];
      time_lo   = move_time[7:0];
      time_hi   = move_time[15:8];
    end else begin
      len_byte  = ReadLen;
      code_byte = ReadCode;
      angle_lo  = 8'd0;
      angle_hi  = 8'd0;
      time_lo   = 8'd0;
      time_hi   = 8'd0;
    end
    sum = 8'(servo_id + len_byte + code_byte + angle_lo + angle_hi + time_lo + time_hi);
    chk = sum ^ ByteMask;
  end

  always_comb begin
    frame.data    = '0;
    frame.data[0] = HdrByte;
    frame.data[1] = HdrByte;
    frame.data[2] = servo_id;
    frame.data[3] = len_byte;
    frame.data[4] = code_byte;
    if (cmd == CmdMove) begin
      frame.data[5] = angle_lo;
      frame.data[6] = angle_hi;
      frame.data[7] = time_lo;
      frame.data[8] = time_hi;
      frame.data[9] = chk;
      frame.count   = MoveBytes;
    end else begin
      frame.data[5] = chk;
      frame.count   = ReadBytes;
    end
  end

endmodule

@@ rtl/servo_command_packet_framer.sv @@
// Top level of the servo command packet framer.
// Registers built frames, then shifts them out one byte per transaction; uses svpf_frame_build.
// Depends on svpf_pkg.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------------
//   in      | input     | in_valid, in_stall  | cmd, servo_id, target_angle, move_time, link_up
//   out     | output    | out_valid, out_stall| out_byte, last
//
// A command is framed in the cycle it is accepted and held in a pending frame register.
// The active frame register emits one byte per cycle into the output register while the output
// is not stalled; a move frame has 10 bytes and a position read 6, and the byte shifter sets the rate.
// A command with link_up low is accepted and produces no transaction.
// Reset (rst, synchronous) empties the pending, active and output registers.
// A stalled output holds its byte; input stalls while the pending frame is occupied.
module servo_command_packet_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  servo_id,
  input  logic [15:0] target_angle,
  input  logic [15:0] move_time,
  input  logic        link_up,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last
);
  import svpf_pkg::*;

  frame_t            built;
  frame_t            pend;
  logic              pend_valid;
  logic [FrameBytes-1:0][7:0] act_data;
  logic [CountW-1:0] rem;
  logic              act_valid;

  logic in_acc;
  logic out_load;
  logic emit;
  logic act_done;
  logic act_free;
  logic pend_to_act;

  svpf_frame_build u_build (
    .cmd          (cmd),
    .servo_id     (servo_id),
    .target_angle (target_angle),
    .move_time    (move_time),
    .frame        (built)
  );

  assign in_stall    = pend_valid;
  assign in_acc      = in_valid && !in_stall;
  assign out_load    = !out_valid || !out_stall;
  assign emit        = act_valid && out_load;
  assign act_done    = emit && (rem == CountW'(1));
  assign act_free    = !act_valid || act_done;
  assign pend_to_act = pend_valid && act_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      act_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_acc && link_up) begin
        pend_valid <= 1'b1;
      end else if (pend_to_act) begin
        pend_valid <= 1'b0;
      end
      if (pend_to_act) begin
        act_valid <= 1'b1;
      end else if (act_done) begin
        act_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && link_up) begin
      pend <= built;
    end
    if (pend_to_act) begin
      act_data <= pend.data;
      rem      <= pend.count;
    end else if (emit) begin
      act_data <= {8'd0, act_data[FrameBytes-1:1]};
      rem      <= rem - CountW'(1);
    end
    if (emit) begin
      out_byte <= act_data[0];
      last     <= (rem == CountW'(1));
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    act_valid |-> (rem != '0) && (rem <= MoveBytes))
    else $error("active frame has no bytes left or too many");

  a_pend_load: assert property (@(posedge clk) disable iff (rst)
    in_acc && link_up |=> pend_valid && ((pend.count == MoveBytes) || (pend.count == ReadBytes)))
    else $error("pending frame not loaded with a valid length");

  a_link_down: assert property (@(posedge clk) disable iff (rst)
    in_acc && !link_up |=> !pend_valid)
    else $error("command with link down produced a frame");

  a_act_source: assert property (@(posedge clk) disable iff (rst)
    $rose(act_valid) |-> $past(pend_valid))
    else $error("active frame started without a pending frame");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    act_done |=> out_valid && last)
    else $error("final byte of a frame not marked last");

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the servo command packet framer.
// Drives a directed table and random servo commands, predicts or looks up each packet and checks every byte.
// Depends on svpf_pkg and servo_command_packet_framer.
module tb;
  import svpf_pkg::*;

  localparam int RandItems  = 380;
  localparam int HoldStart  = 120;
  localparam int HoldCycles = 150;
  localparam int DrainWait  = 24;
  localparam int CycleLimit = 200000;
  localparam int ShowErrors = 10;

  typedef struct {
    logic        c;
    logic [7:0]  id;
    logic [15:0] ang;
    logic [15:0] mt;
    logic        lk;
    int          nexp;
    logic [79:0] pkt;
  } cmd_row_t;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
  } pkt_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = CmdMove;
  logic [7:0]  servo_id = 8'h00;
  logic [15:0] target_angle = 16'h0000;
  logic [15:0] move_time = 16'h0000;
  logic        link_up = 1'b0;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        last;

  logic rx_gap = 1'b0;
  logic rx_hold = 1'b0;
  logic calm = 1'b0;

  pkt_byte_t pending_bytes[$];
  pkt_byte_t rx_want;
  cmd_row_t  dir_rows[$];

  int errors = 0;
  int cycle_cnt = 0;
  int rx_gap_left = 0;
  int n_items = 0;
  int n_linked = 0;
  int n_dropped = 0;
  int bytes_seen = 0;
  int packets_seen = 0;
  int in_held = 0;

  assign out_stall = rx_gap | rx_hold;

  servo_command_packet_framer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .servo_id     (servo_id),
    .target_angle (target_angle),
    .move_time    (move_time),
    .link_up      (link_up),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last         (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d bytes still expected", cycle_cnt,
             pending_bytes.size());
    $display("tb NOT OK");
    $finish;
  end

  function automatic cmd_row_t row(logic c, logic [7:0] id, logic [15:0] ang,
                                   logic [15:0] mt, logic lk, int nexp, logic [79:0] pkt);
    cmd_row_t r;
    r.c = c;
    r.id = id;
    r.ang = ang;
    r.mt = mt;
    r.lk = lk;
    r.nexp = nexp;
    r.pkt = pkt;
    return r;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_byte(logic [7:0] data, logic is_last);
    pkt_byte_t b;
    b.data = data;
    b.is_last = is_last;
    pending_bytes.push_back(b);
  endfunction

  function automatic void predict_packet(cmd_row_t r);
    logic [7:0] body [7];
    logic [7:0] sum;
    int nbody;
    if (!r.lk) return;
    body[0] = r.id;
    if (r.c == CmdMove) begin
      body[1] = MoveLen;
      body[2] = MoveCode;
      body[3] = r.ang[7:0];
      body[4] = r.ang[15:8];
      body[5] = r.mt[7:0];
      body[6] = r.mt[15:8];
      nbody = 7;
    end else begin
      body[1] = ReadLen;
      body[2] = ReadCode;
      nbody = 3;
    end
    sum = 8'h00;
    push_byte(HdrByte, 1'b0);
    push_byte(HdrByte, 1'b0);
    for (int i = 0; i < nbody; i++) begin
      sum = sum + body[i];
      push_byte(body[i], 1'b0);
    end
    push_byte(sum ^ ByteMask, 1'b1);
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= ShowErrors) begin
      $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    end
  endtask

  task automatic send_cmd(cmd_row_t r);
    in_valid <= 1'b1;
    cmd <= r.c;
    servo_id <= r.id;
    target_angle <= r.ang;
    move_time <= r.mt;
    link_up <= r.lk;
    @(posedge clk);
    while (in_stall) begin
      in_held++;
      @(posedge clk);
    end
    if (r.nexp < 0) begin
      predict_packet(r);
    end else begin
      for (int k = 0; k < r.nexp; k++) begin
        push_byte(r.pkt[79 - 8 * k -: 8], k == r.nexp - 1);
      end
    end
    n_items++;
    if (!r.lk) n_dropped++;
  endtask

  task automatic maybe_gap();
    if (!calm && !rx_hold && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        note_error($sformatf("unexpected byte %02h last %0b", out_byte, last));
      end else begin
        rx_want = pending_bytes.pop_front();
        if (out_byte !== rx_want.data) begin
          note_error($sformatf("out_byte expected %02h got %02h", rx_want.data, out_byte));
        end
        if (last !== rx_want.is_last) begin
          note_error($sformatf("last expected %0b got %0b", rx_want.is_last, last));
        end
        bytes_seen++;
        if (last) packets_seen++;
      end
    end
    if (rx_gap_left > 0) begin
      rx_gap_left = rx_gap_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rx_gap_left = $urandom_range(1, 8);
    end
    rx_gap <= (rx_gap_left > 0);
  end

  initial begin
    wait (n_linked >= HoldStart);
    @(posedge clk);
    rx_hold <= 1'b1;
    for (int i = 0; i < HoldCycles; i++) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    cmd_row_t r;
    dir_rows.push_back(row(CmdRead, 8'h00, 16'h0000, 16'h0000, 1'b1, 6,
                           80'h5555_0003_1CE0_0000_0000));
    dir_rows.push_back(row(CmdMove, 8'h00, 16'h0000, 16'h0000, 1'b1, 10,
                           80'h5555_0007_0100_0000_00F7));
    dir_rows.push_back(row(CmdMove, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 10,
                           80'h5555_FF07_01FF_FFFF_FFFC));
    dir_rows.push_back(row(CmdRead, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 6,
                           80'h5555_FF03_1CE1_0000_0000));
    dir_rows.push_back(row(CmdMove, 8'hF7, 16'h0000, 16'h0000, 1'b1, 10,
                           80'h5555_F707_0100_0000_0000));
    dir_rows.push_back(row(CmdRead, 8'hE0, 16'h1234, 16'h5678, 1'b1, 6,
                           80'h5555_E003_1C00_0000_0000));
    dir_rows.push_back(row(CmdMove, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 0, 80'h0));
    dir_rows.push_back(row(CmdRead, 8'h10, 16'h0000, 16'h0000, 1'b0, 0, 80'h0));
    dir_rows.push_back(row(CmdMove, 8'h55, 16'h5555, 16'hAAAA, 1'b1, -1, 80'h0));
    dir_rows.push_back(row(CmdMove, 8'hAA, 16'hAAAA, 16'h5555, 1'b1, -1, 80'h0));
    dir_rows.push_back(row(CmdRead, 8'h12, 16'h1234, 16'h5678, 1'b1, -1, 80'h0));
    dir_rows.push_back(row(CmdMove, 8'h01, 16'h0001, 16'h8000, 1'b1, -1, 80'h0));
    dir_rows.push_back(row(CmdMove, 8'h80, 16'h8000, 16'h0001, 1'b1, -1, 80'h0));
    dir_rows.push_back(row(CmdMove, 8'h3C, 16'h00FF, 16'hFF00, 1'b1, -1, 80'h0));
    dir_rows.push_back(row(CmdMove, 8'hC3, 16'hFF00, 16'h00FF, 1'b1, -1, 80'h0));
    dir_rows.push_back(row(CmdMove, 8'h00, 16'h0000, 16'h0000, 1'b0, 0, 80'h0));
    dir_rows.push_back(row(CmdRead, 8'h7F, 16'h0000, 16'h0000, 1'b1, -1, 80'h0));
    dir_rows.push_back(row(CmdRead, 8'h01, 16'hFFFF, 16'h0000, 1'b1, -1, 80'h0));
    dir_rows.push_back(row(CmdMove, 8'hFE, 16'h7FFF, 16'hFFFE, 1'b1, -1, 80'h0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i]);
      maybe_gap();
    end

    // Calm stretches have no idling on either side; the final one runs to the end.
    while (n_items < RandItems) begin
      r = row($urandom_range(0, 1) ? CmdRead : CmdMove, 8'(pick16()), pick16(), pick16(),
              $urandom_range(0, 9) != 0, -1, 80'h0);
      calm <= (n_items >= 200 && n_items < 240) || (n_items >= RandItems - 60);
      send_cmd(r);
      if (r.lk) n_linked++;
      maybe_gap();
    end
    in_valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("ran %0d commands (%0d with link down): %0d packets, %0d bytes checked",
             n_items, n_dropped, packets_seen, bytes_seen);
    $display("input was held off for %0d cycles; %0d mismatches", in_held, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/svpf_pkg.sv
rtl/svpf_frame_build.sv
rtl/servo_command_packet_framer.sv
tb/sv/tb.sv
